// ===== rtl/uram_pkg.sv =====
// Shared types, codes and the CRC8 helper for the UART register-access master.
// Used by uram_core and uart_register_access_master; no other dependencies.
package uram_pkg;

	// Datagram framing
	localparam logic [7:0] SYNC_BYTE  = 8'h05;
	localparam logic [7:0] WRITE_FLAG = 8'h80;
	localparam logic [7:0] CRC_POLY   = 8'h07;

	// Configuration register defaults
	localparam logic [15:0] ECHO_TIMEOUT_RST  = 16'd5;
	localparam logic [15:0] REPLY_TIMEOUT_RST = 16'd1000;

	// Command codes
	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_READ  = 2'd1,
		CMD_RXB   = 2'd2,
		CMD_TICK  = 2'd3
	} cmd_t;

	// Transaction status codes
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_ECHO_ERR  = 2'd1,
		ST_REPLY_TMO = 2'd2,
		ST_CRC_ERR   = 2'd3
	} status_t;

	// Transaction phase
	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_SEND_WR = 2'd1,
		PH_SEND_RD = 2'd2,
		PH_REPLY   = 2'd3
	} phase_t;

	// Configuration register indexes
	typedef enum logic {
		REG_ECHO_TMO  = 1'b0,
		REG_REPLY_TMO = 1'b1
	} cfg_reg_t;

	// One input item
	typedef struct packed {
		cmd_t        cmd;
		logic [7:0]  slave_addr;
		logic [6:0]  reg_addr;
		logic [31:0] write_data;
		logic [7:0]  rx_byte;
	} item_t;

	// One result item
	typedef struct packed {
		logic        tx_valid;
		logic [7:0]  tx_byte;
		logic        done_res;
		status_t     status;
		logic [31:0] read_data;
		logic        busy_res;
	} result_t;

	// CRC8 over one byte, data taken LSB first, CRC MSB tested
	function automatic logic [7:0] crc8_step(input logic [7:0] crc_in, input logic [7:0] data);
		logic [7:0] c;
		logic [7:0] d;
		c = crc_in;
		d = data;
		for (int k = 0; k < 8; k++) begin
			if (c[7] ^ d[0]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
			d = {1'b0, d[7:1]};
		end
		return c;
	endfunction

endpackage

// ===== rtl/uram_core.sv =====
// Transaction state and per-item update of the UART register-access master.
// Depends on uram_pkg; one item is folded into the state each cycle step_en is high.
module uram_core
	import uram_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step_en,
	input  item_t       item,
	input  logic [15:0] echo_tmo,
	input  logic [15:0] reply_tmo,
	output result_t     res
);

	phase_t      phase_q, phase_n;
	logic [2:0]  idx_q, idx_n;
	logic [7:0]  crc_q, crc_n;
	logic [15:0] wait_q, wait_n;
	logic [7:0]  slave_q, slave_n;
	logic [6:0]  reg_q, reg_n;
	logic [31:0] value_q, value_n;
	logic [7:0]  echo_q, echo_n;
	logic [31:0] shift_q, shift_n;

	logic [2:0]  last_idx;
	logic [15:0] wait_inc;
	logic [7:0]  next_byte;

	// Byte of the outgoing datagram at a given position; the last one is the CRC
	function automatic logic [7:0] dgram_byte(
		input phase_t      ph,
		input logic [2:0]  idx,
		input logic [7:0]  crc,
		input logic [7:0]  slave,
		input logic [6:0]  regad,
		input logic [31:0] value
	);
		logic [2:0] last;
		logic [7:0] b;
		last = (ph == PH_SEND_WR) ? 3'd7 : 3'd3;
		unique case (idx)
			3'd0: b = SYNC_BYTE;
			3'd1: b = slave;
			3'd2: b = (ph == PH_SEND_WR) ? ({1'b0, regad} | WRITE_FLAG) : {1'b0, regad};
			3'd3: b = value[31:24];
			3'd4: b = value[23:16];
			3'd5: b = value[15:8];
			default: b = value[7:0];
		endcase
		if (idx == last) begin
			b = crc;
		end
		return b;
	endfunction

	assign last_idx  = (phase_q == PH_SEND_WR) ? 3'd7 : 3'd3;
	assign wait_inc  = wait_q + 16'd1;
	assign next_byte = dgram_byte(phase_q, idx_q + 3'd1, crc_q, slave_q, reg_q, value_q);

	// Next state and result for the item at hand
	always_comb begin
		phase_n = phase_q;
		idx_n   = idx_q;
		crc_n   = crc_q;
		wait_n  = wait_q;
		slave_n = slave_q;
		reg_n   = reg_q;
		value_n = value_q;
		echo_n  = echo_q;
		shift_n = shift_q;
		res     = '0;

		if (item.cmd == CMD_WRITE || item.cmd == CMD_READ) begin
			// start: ignored while a transaction is running
			if (phase_q == PH_IDLE) begin
				slave_n      = item.slave_addr;
				reg_n        = item.reg_addr;
				value_n      = (item.cmd == CMD_WRITE) ? item.write_data : 32'd0;
				phase_n      = (item.cmd == CMD_WRITE) ? PH_SEND_WR : PH_SEND_RD;
				idx_n        = 3'd0;
				shift_n      = 32'd0;
				echo_n       = SYNC_BYTE;
				crc_n        = crc8_step(8'd0, SYNC_BYTE);
				wait_n       = 16'd0;
				res.tx_valid = 1'b1;
				res.tx_byte  = SYNC_BYTE;
			end
		end else if (phase_q == PH_SEND_WR || phase_q == PH_SEND_RD) begin
			if (item.cmd == CMD_RXB) begin
				// echo check, then next byte or end of datagram
				if (item.rx_byte != echo_q) begin
					res.done_res = 1'b1;
					res.status   = ST_ECHO_ERR;
					phase_n      = PH_IDLE;
				end else if (idx_q == last_idx) begin
					if (phase_q == PH_SEND_WR) begin
						res.done_res = 1'b1;
						phase_n      = PH_IDLE;
					end else begin
						phase_n = PH_REPLY;
						idx_n   = 3'd0;
						crc_n   = 8'd0;
						wait_n  = 16'd0;
						shift_n = 32'd0;
					end
				end else begin
					idx_n        = idx_q + 3'd1;
					echo_n       = next_byte;
					crc_n        = crc8_step(crc_q, next_byte);
					wait_n       = 16'd0;
					res.tx_valid = 1'b1;
					res.tx_byte  = next_byte;
				end
			end else begin
				wait_n = wait_inc;
				if (wait_inc >= echo_tmo) begin
					res.done_res = 1'b1;
					res.status   = ST_ECHO_ERR;
					phase_n      = PH_IDLE;
				end
			end
		end else if (phase_q == PH_REPLY) begin
			if (item.cmd == CMD_RXB) begin
				// reply byte: last one is the CRC
				wait_n = 16'd0;
				if (idx_q == 3'd7) begin
					res.done_res = 1'b1;
					phase_n      = PH_IDLE;
					if (item.rx_byte == crc_q) begin
						res.read_data = shift_q;
					end else begin
						res.status = ST_CRC_ERR;
					end
				end else begin
					crc_n = crc8_step(crc_q, item.rx_byte);
					if (idx_q >= 3'd3) begin
						shift_n = {shift_q[23:0], item.rx_byte};
					end
					idx_n = idx_q + 3'd1;
				end
			end else begin
				wait_n = wait_inc;
				if (wait_inc >= reply_tmo) begin
					res.done_res = 1'b1;
					res.status   = ST_REPLY_TMO;
					phase_n      = PH_IDLE;
				end
			end
		end

		res.busy_res = (phase_n != PH_IDLE);
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			idx_q   <= '0;
			crc_q   <= '0;
			wait_q  <= '0;
			slave_q <= '0;
			reg_q   <= '0;
			value_q <= '0;
			echo_q  <= '0;
			shift_q <= '0;
		end else if (step_en) begin
			phase_q <= phase_n;
			idx_q   <= idx_n;
			crc_q   <= crc_n;
			wait_q  <= wait_n;
			slave_q <= slave_n;
			reg_q   <= reg_n;
			value_q <= value_n;
			echo_q  <= echo_n;
			shift_q <= shift_n;
		end
	end

	// A finished transaction leaves the block idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && res.done_res |=> phase_q == PH_IDLE)
		else $error("phase not idle after transaction end");

	// A byte to send only while a datagram is in flight
	a_tx_busy: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && res.tx_valid |-> res.busy_res && !res.done_res)
		else $error("tx byte outside an active transaction");

	// Error status only with an ending transaction and no read data
	a_status_done: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && res.status != ST_OK |-> res.done_res && res.read_data == 32'd0)
		else $error("status without transaction end");

	// Byte position stays within the datagram length while sending a read request
	a_rd_idx: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_SEND_RD |-> idx_q <= 3'd3)
		else $error("read request byte index out of range");

endmodule

// ===== rtl/uart_register_access_master.sv =====
// Flow: an accepted item is held in the input register and, once the result
// register is free or being emptied, its result is loaded into the result register;
// while out_ready holds a waiting result, the item stays in the input register.
// Throughput: one item per cycle unless out_ready holds back a waiting result; the
// per-item update is a single registered pass whose longest path is the datagram byte
// select and one CRC8 byte step.
// Reset: transaction idle, core state and valid flags cleared, echo timeout 5 ticks, reply timeout 1000.
// Depends on uram_pkg and uram_core.
module uart_register_access_master
	import uram_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// input item channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  cmd,
	input  logic [7:0]  slave_addr,
	input  logic [6:0]  reg_addr,
	input  logic [31:0] write_data,
	input  logic [7:0]  rx_byte,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic        tx_valid,
	output logic [7:0]  tx_byte,
	output logic        done_res,
	output logic [1:0]  status,
	output logic [31:0] read_data,
	output logic        busy_res,
	// configuration write port
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	logic        valid_s1;
	item_t       item_s1;
	logic        out_valid_q;
	result_t     out_q;
	result_t     res;
	logic        advance;
	logic [15:0] echo_tmo_q;
	logic [15:0] reply_tmo_q;

	// Item in stage 1 moves on when the result register is free or being emptied
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			echo_tmo_q  <= ECHO_TIMEOUT_RST;
			reply_tmo_q <= REPLY_TIMEOUT_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_ECHO_TMO:  echo_tmo_q  <= cfg_data;
				REG_REPLY_TMO: reply_tmo_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.cmd        <= cmd_t'(cmd);
			item_s1.slave_addr <= slave_addr;
			item_s1.reg_addr   <= reg_addr;
			item_s1.write_data <= write_data;
			item_s1.rx_byte    <= rx_byte;
		end
	end

	// Transaction engine
	uram_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step_en   (advance),
		.item      (item_s1),
		.echo_tmo  (echo_tmo_q),
		.reply_tmo (reply_tmo_q),
		.res       (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign tx_valid  = out_q.tx_valid;
	assign tx_byte   = out_q.tx_byte;
	assign done_res  = out_q.done_res;
	assign status    = out_q.status;
	assign read_data = out_q.read_data;
	assign busy_res  = out_q.busy_res;

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for uart_register_access_master: register write and read datagrams,
// echo checks, timeouts and reply CRC, predicted per accepted command and compared per result field.
// Depends on uram_pkg (types, codes, framing constants) and the block under test.
module tb_top;
	import uram_pkg::*;

	// Broken-sequence kinds used by the stimulus generator
	typedef enum int {
		FLT_NONE,
		FLT_ECHO_BAD,
		FLT_ECHO_TMO,
		FLT_REPLY_TMO,
		FLT_REPLY_CRC,
		FLT_BUSY_START
	} fault_t;

	localparam int HOLD_AT     = 500;
	localparam int HOLD_CYCLES = 400;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  cmd = CMD_TICK;
	logic [7:0]  slave_addr = '0;
	logic [6:0]  reg_addr = '0;
	logic [31:0] write_data = '0;
	logic [7:0]  rx_byte = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        tx_valid;
	logic [7:0]  tx_byte;
	logic        done_res;
	logic [1:0]  status;
	logic [31:0] read_data;
	logic        busy_res;
	logic        cfg_we = 1'b0;
	logic        cfg_index = REG_ECHO_TMO;
	logic [15:0] cfg_data = '0;

	// Stimulus and scoreboard storage
	item_t     pending_cmds[$];
	result_t   expected_responses[$];
	int        cmds_queued = 0;
	int        cmds_accepted = 0;
	int        stim_count = 0;
	int        responses_seen = 0;
	int        err_count = 0;
	logic      in_xfer = 1'b0;
	int        send_idle_pct = 0;
	int        recv_idle_pct = 0;
	int        hold_left = 0;
	bit        hold_done = 1'b0;

	// Predictor state and its copy of the configuration
	phase_t      m_phase = PH_IDLE;
	logic [2:0]  m_idx = '0;
	logic [7:0]  m_crc = '0;
	logic [15:0] m_ticks = '0;
	logic [7:0]  m_slave = '0;
	logic [6:0]  m_reg = '0;
	logic [31:0] m_value = '0;
	logic [7:0]  m_echo = '0;
	logic [31:0] m_reply = '0;
	logic [15:0] echo_limit = ECHO_TIMEOUT_RST;
	logic [15:0] reply_limit = REPLY_TIMEOUT_RST;

	uart_register_access_master u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.cmd        (cmd),
		.slave_addr (slave_addr),
		.reg_addr   (reg_addr),
		.write_data (write_data),
		.rx_byte    (rx_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.tx_valid   (tx_valid),
		.tx_byte    (tx_byte),
		.done_res   (done_res),
		.status     (status),
		.read_data  (read_data),
		.busy_res   (busy_res),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	// CRC8, poly 0x07, data LSB first, CRC MSB tested
	function automatic logic [7:0] crc8_fold(input logic [7:0] acc, input logic [7:0] b);
		for (int k = 0; k < 8; k++) begin
			if (acc[7] ^ b[0]) begin
				acc = {acc[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				acc = {acc[6:0], 1'b0};
			end
			b = {1'b0, b[7:1]};
		end
		return acc;
	endfunction

	// Current datagram byte; it becomes the awaited echo and is folded into the CRC
	function automatic logic [7:0] next_datagram_byte();
		logic [7:0] b;
		logic [2:0] last;
		last = (m_phase == PH_SEND_WR) ? 3'd7 : 3'd3;
		if (m_idx == last) begin
			b = m_crc;
		end else begin
			case (m_idx)
				3'd0: b = SYNC_BYTE;
				3'd1: b = m_slave;
				3'd2: b = (m_phase == PH_SEND_WR) ? ({1'b0, m_reg} | WRITE_FLAG) : {1'b0, m_reg};
				3'd3: b = m_value[31:24];
				3'd4: b = m_value[23:16];
				3'd5: b = m_value[15:8];
				default: b = m_value[7:0];
			endcase
		end
		m_echo = b;
		m_crc = crc8_fold(m_crc, b);
		m_ticks = '0;
		return b;
	endfunction

	// Expected response of the master to one command
	task automatic predict_response(input item_t it, output result_t r);
		logic [2:0] last;
		r = '0;
		case (it.cmd)
			CMD_WRITE, CMD_READ: begin
				if (m_phase == PH_IDLE) begin
					m_slave = it.slave_addr;
					m_reg = it.reg_addr;
					m_value = (it.cmd == CMD_WRITE) ? it.write_data : '0;
					m_phase = (it.cmd == CMD_WRITE) ? PH_SEND_WR : PH_SEND_RD;
					m_idx = '0;
					m_crc = '0;
					m_reply = '0;
					r.tx_byte = next_datagram_byte();
					r.tx_valid = 1'b1;
				end
			end
			default: begin
				if (m_phase == PH_SEND_WR || m_phase == PH_SEND_RD) begin
					last = (m_phase == PH_SEND_WR) ? 3'd7 : 3'd3;
					if (it.cmd == CMD_RXB) begin
						if (it.rx_byte != m_echo) begin
							r.done_res = 1'b1;
							r.status = ST_ECHO_ERR;
							m_phase = PH_IDLE;
						end else if (m_idx >= last) begin
							if (m_phase == PH_SEND_WR) begin
								r.done_res = 1'b1;
								r.status = ST_OK;
								m_phase = PH_IDLE;
							end else begin
								m_phase = PH_REPLY;
								m_idx = '0;
								m_crc = '0;
								m_ticks = '0;
								m_reply = '0;
							end
						end else begin
							m_idx = m_idx + 3'd1;
							r.tx_byte = next_datagram_byte();
							r.tx_valid = 1'b1;
						end
					end else begin
						m_ticks = m_ticks + 16'd1;
						if (m_ticks >= echo_limit) begin
							r.done_res = 1'b1;
							r.status = ST_ECHO_ERR;
							m_phase = PH_IDLE;
						end
					end
				end else if (m_phase == PH_REPLY) begin
					if (it.cmd == CMD_RXB) begin
						m_ticks = '0;
						if (m_idx == 3'd7) begin
							r.done_res = 1'b1;
							m_phase = PH_IDLE;
							if (it.rx_byte == m_crc) begin
								r.status = ST_OK;
								r.read_data = m_reply;
							end else begin
								r.status = ST_CRC_ERR;
							end
						end else begin
							m_crc = crc8_fold(m_crc, it.rx_byte);
							if (m_idx >= 3'd3) m_reply = {m_reply[23:0], it.rx_byte};
							m_idx = m_idx + 3'd1;
						end
					end else begin
						m_ticks = m_ticks + 16'd1;
						if (m_ticks >= reply_limit) begin
							r.done_res = 1'b1;
							r.status = ST_REPLY_TMO;
							m_phase = PH_IDLE;
						end
					end
				end
			end
		endcase
		r.busy_res = (m_phase != PH_IDLE);
	endtask

	// Stimulus helpers
	function automatic item_t random_item(input cmd_t c);
		item_t it;
		it.cmd = c;
		it.slave_addr = 8'($urandom);
		it.reg_addr = 7'($urandom);
		it.write_data = $urandom;
		it.rx_byte = 8'($urandom);
		return it;
	endfunction

	task automatic push_item(input item_t it, input bit counted);
		pending_cmds.push_back(it);
		cmds_queued++;
		if (counted) stim_count++;
	endtask

	task automatic push_ticks(input int n);
		repeat (n) push_item(random_item(CMD_TICK), 1'b1);
	endtask

	// Ticks to insert before a byte, always short of the timeout
	function automatic int gap_ticks(input logic [15:0] limit);
		if (limit <= 16'd1) return 0;
		if (limit <= 16'd13 && $urandom_range(7) == 0) return int'(limit) - 1;
		if ($urandom_range(3) != 0) return 0;
		return (limit > 16'd3) ? $urandom_range(2, 1) : 1;
	endfunction

	// One transaction: start, echoes, and for a read the reply, optionally broken
	task automatic queue_transaction(input cmd_t kind, input logic [7:0] slave,
			input logic [6:0] rg, input logic [31:0] value, input fault_t fault, input bit gaps);
		logic [7:0] frame [8];
		logic [7:0] reply [8];
		logic [7:0] acc;
		int len;
		int hit;
		item_t it;
		fault_t f;
		// timeouts are only provoked where the tick count stays small
		f = fault;
		if (f == FLT_ECHO_TMO && echo_limit > 16'd40) f = FLT_ECHO_BAD;
		if (f == FLT_REPLY_TMO && reply_limit > 16'd40) f = FLT_REPLY_CRC;
		len = (kind == CMD_WRITE) ? 8 : 4;
		frame[0] = SYNC_BYTE;
		frame[1] = slave;
		frame[2] = (kind == CMD_WRITE) ? ({1'b0, rg} | WRITE_FLAG) : {1'b0, rg};
		frame[3] = value[31:24];
		frame[4] = value[23:16];
		frame[5] = value[15:8];
		frame[6] = value[7:0];
		acc = '0;
		for (int i = 0; i < len - 1; i++) acc = crc8_fold(acc, frame[i]);
		frame[len - 1] = acc;
		it = random_item(kind);
		it.slave_addr = slave;
		it.reg_addr = rg;
		if (kind == CMD_WRITE) it.write_data = value;
		push_item(it, 1'b1);
		// echoes of the sent bytes
		hit = $urandom_range(len - 1, 0);
		for (int i = 0; i < len; i++) begin
			if (i == hit && f == FLT_ECHO_TMO) begin
				push_ticks(int'(echo_limit));
				return;
			end
			if (gaps) push_ticks(gap_ticks(echo_limit));
			if (i == hit && f == FLT_BUSY_START)
				push_item(random_item($urandom_range(1) ? CMD_READ : CMD_WRITE), 1'b1);
			it = random_item(CMD_RXB);
			if (i == hit && f == FLT_ECHO_BAD) begin
				it.rx_byte = frame[i] ^ 8'($urandom_range(255, 1));
				push_item(it, 1'b1);
				return;
			end
			it.rx_byte = frame[i];
			push_item(it, 1'b1);
		end
		if (kind == CMD_WRITE) return;
		// reply datagram, data in bytes 3..6
		reply[0] = 8'($urandom);
		reply[1] = 8'($urandom);
		reply[2] = 8'($urandom);
		reply[3] = value[31:24];
		reply[4] = value[23:16];
		reply[5] = value[15:8];
		reply[6] = value[7:0];
		acc = '0;
		for (int j = 0; j < 7; j++) acc = crc8_fold(acc, reply[j]);
		reply[7] = acc;
		if (f == FLT_REPLY_CRC) reply[7] = acc ^ 8'($urandom_range(255, 1));
		hit = $urandom_range(7, 0);
		for (int j = 0; j < 8; j++) begin
			if (j == hit && f == FLT_REPLY_TMO) begin
				push_ticks(int'(reply_limit));
				return;
			end
			if (gaps) push_ticks(gap_ticks(reply_limit));
			it = random_item(CMD_RXB);
			it.rx_byte = reply[j];
			push_item(it, 1'b1);
		end
	endtask

	// Mostly well-formed transactions with random content, some broken, some idle noise
	task automatic run_random(input int target);
		int start;
		int pick;
		fault_t f;
		start = stim_count;
		while (stim_count - start < target) begin
			pick = $urandom_range(99);
			if (pick < 8) begin
				repeat ($urandom_range(3, 1))
					push_item(random_item($urandom_range(1) ? CMD_TICK : CMD_RXB), 1'b0);
			end else begin
				pick = $urandom_range(99);
				if (pick < 55) f = FLT_NONE;
				else if (pick < 65) f = FLT_ECHO_BAD;
				else if (pick < 72) f = FLT_ECHO_TMO;
				else if (pick < 79) f = FLT_REPLY_TMO;
				else if (pick < 88) f = FLT_REPLY_CRC;
				else f = FLT_BUSY_START;
				queue_transaction($urandom_range(1) ? CMD_READ : CMD_WRITE, 8'($urandom),
					7'($urandom), $urandom, f, 1'b1);
			end
		end
	endtask

	// Register write, only issued while the master is idle
	task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_ECHO_TMO) echo_limit = val;
		else reply_limit = val;
	endtask

	// Every queued command transferred and every response checked
	task automatic wait_drained();
		do @(negedge clk);
		while (cmds_accepted != cmds_queued || expected_responses.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	// Clock
	initial begin
		forever #5 clk = ~clk;
	end

	// Run limit
	initial begin
		#3000000;
		$display("Simulation FAILED");
		$finish;
	end

	// Command driver: offers the next queued command once the previous one has transferred
	always @(negedge clk) begin
		item_t nxt;
		if (arst_n && (!in_valid || in_xfer)) begin
			if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				nxt = pending_cmds.pop_front();
				in_valid <= 1'b1;
				cmd <= nxt.cmd;
				slave_addr <= nxt.slave_addr;
				reg_addr <= nxt.reg_addr;
				write_data <= nxt.write_data;
				rx_byte <= nxt.rx_byte;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Input transfers: predict the response of each accepted command
	always @(posedge clk) begin
		item_t cur;
		result_t resp;
		in_xfer <= in_valid && in_ready;
		if (in_valid && in_ready) begin
			cur.cmd = cmd_t'(cmd);
			cur.slave_addr = slave_addr;
			cur.reg_addr = reg_addr;
			cur.write_data = write_data;
			cur.rx_byte = rx_byte;
			predict_response(cur, resp);
			expected_responses.push_back(resp);
			cmds_accepted++;
		end
	end

	// Response back-pressure, with one long hold-off while commands are still queued
	always @(negedge clk) begin
		if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (!hold_done && responses_seen >= HOLD_AT && pending_cmds.size() > 20) begin
			out_ready <= 1'b0;
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Response monitor: compare each transfer with the oldest prediction
	always @(posedge clk) begin
		result_t want;
		if (out_valid && out_ready) begin
			responses_seen++;
			if (expected_responses.size() == 0) begin
				$error("response with no command pending");
				err_count++;
			end else begin
				want = expected_responses.pop_front();
				if (tx_valid !== want.tx_valid) begin
					$error("tx_valid: expected %0h, got %0h", want.tx_valid, tx_valid);
					err_count++;
				end
				if (tx_byte !== want.tx_byte) begin
					$error("tx_byte: expected %0h, got %0h", want.tx_byte, tx_byte);
					err_count++;
				end
				if (done_res !== want.done_res) begin
					$error("done_res: expected %0h, got %0h", want.done_res, done_res);
					err_count++;
				end
				if (status !== want.status) begin
					$error("status: expected %0h, got %0h", want.status, status);
					err_count++;
				end
				if (read_data !== want.read_data) begin
					$error("read_data: expected %0h, got %0h", want.read_data, read_data);
					err_count++;
				end
				if (busy_res !== want.busy_res) begin
					$error("busy_res: expected %0h, got %0h", want.busy_res, busy_res);
					err_count++;
				end
			end
		end
	end

	// Test sequence
	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset timeouts; sender idles lightly, receiver heavily
		send_idle_pct = 33;
		recv_idle_pct = 77;
		// extreme fields with a start while busy, a zero read, line byte and tick while idle
		queue_transaction(CMD_WRITE, 8'hFF, 7'h7F, 32'hFFFF_FFFF, FLT_BUSY_START, 1'b0);
		queue_transaction(CMD_READ, 8'h00, 7'h00, 32'h0000_0000, FLT_NONE, 1'b0);
		push_item(random_item(CMD_RXB), 1'b0);
		push_item(random_item(CMD_TICK), 1'b0);
		run_random(330);
		wait_drained();

		// shortest timeouts; roles of the two sides swapped
		send_idle_pct = 77;
		recv_idle_pct = 33;
		write_reg(REG_ECHO_TMO, 16'd1);
		write_reg(REG_REPLY_TMO, 16'd1);
		queue_transaction(CMD_WRITE, 8'($urandom), 7'($urandom), $urandom, FLT_ECHO_TMO, 1'b0);
		queue_transaction(CMD_READ, 8'($urandom), 7'($urandom), $urandom, FLT_REPLY_TMO, 1'b0);
		queue_transaction(CMD_READ, 8'($urandom), 7'($urandom), $urandom, FLT_REPLY_CRC, 1'b0);
		run_random(300);
		wait_drained();

		// longest timeouts, no idling; sender pauses half way until all responses are in
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_reg(REG_ECHO_TMO, 16'hFFFF);
		write_reg(REG_REPLY_TMO, 16'hFFFF);
		run_random(125);
		wait_drained();
		run_random(125);
		wait_drained();

		// small random timeouts so tick runs just short of them land often
		write_reg(REG_ECHO_TMO, 16'($urandom_range(12, 2)));
		write_reg(REG_REPLY_TMO, 16'($urandom_range(12, 2)));
		run_random(250);
		wait_drained();

		if (err_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
